FILE: src/cfx_pkg.sv
// shared constants and types for the cosmic-ray flux cell
package cfx_pkg;

    // default number of fraction bits of the fixed-point format
    localparam int FRAC_BITS_DEF = 16;

    // widths fixed by the word format
    localparam int VAL_W = 32;
    localparam int RHO_W = 31;
    localparam int DEN_W = 62;
    localparam int BSQ_W = 64;

    // configuration register indexes
    localparam logic [1:0] REG_SWEEP  = 2'd0;
    localparam logic [1:0] REG_CHARGE = 2'd1;
    localparam logic [1:0] REG_ENERGY = 2'd2;

    // configuration reset values
    localparam logic [1:0]       SWEEP_RST  = 2'd0;
    localparam logic [RHO_W-1:0] CHARGE_RST = 31'd65536;
    localparam logic             ENERGY_RST = 1'b1;

    // sweep axis codes
    localparam logic [1:0] SWEEP_X = 2'd0;
    localparam logic [1:0] SWEEP_Y = 2'd1;
    localparam logic [1:0] SWEEP_Z = 2'd2;

    // saturation limits
    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

    // one cell as it moves through the front stages
    typedef struct packed {
        logic [2:0][VAL_W-1:0] f;
        logic [2:0][VAL_W-1:0] b;
        logic                  row;
    } cell_t;

    // side data that waits beside the projection dividers
    typedef struct packed {
        logic [2:0][VAL_W-1:0] f;
        logic [2:0][VAL_W-1:0] b;
        logic [2:0]            qneg;
        logic                  bsq_zero;
        logic                  den_zero;
        logic [DEN_W-1:0]      den;
        logic                  row;
    } side1_t;

    // side data that waits beside the flux dividers
    typedef struct packed {
        logic [2:0][VAL_W-1:0] cf;
        logic                  fault;
        logic                  den_zero;
        logic                  row;
        logic [2:0]            neg;
        logic [2:0]            zero;
    } side2_t;

endpackage

FILE: src/cosmic_ray_flux_cell.sv
// top level of the cosmic-ray flux cell pipeline
// pipeline from start to done: 6 front stages, a 33-stage projection divider,
//   4 flux-setup stages, a 33-stage flux divider and one output stage
// throughput: one cell per cycle, set by the fully pipelined dividers; busy stays low
// the result strobe done lasts one cycle; the receiver cannot stall
// reset clears the valid line and loads the configuration reset values
module cosmic_ray_flux_cell #(
    parameter int FRAC_BITS = cfx_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        write_enable,
    input  logic [1:0]  write_index,
    input  logic [30:0] write_data,
    input  logic signed [31:0] force_x,
    input  logic signed [31:0] force_y,
    input  logic signed [31:0] force_z,
    input  logic signed [31:0] field_x,
    input  logic signed [31:0] field_y,
    input  logic signed [31:0] field_z,
    input  logic [30:0] density,
    input  logic        last_in_row,
    output logic        done,
    output logic signed [31:0] clean_force_x,
    output logic signed [31:0] clean_force_y,
    output logic signed [31:0] clean_force_z,
    output logic signed [31:0] flux_field_x,
    output logic signed [31:0] flux_field_y,
    output logic signed [31:0] flux_field_z,
    output logic signed [31:0] flux_energy,
    output logic        divide_fault,
    output logic        row_end
);

    localparam int Q_W    = 32;
    localparam int DL     = Q_W + 1;
    localparam int CNUM_W = 96;
    localparam int FNUM_W = 64 + 2 * FRAC_BITS;
    localparam int LAT    = 6 + DL + 4 + DL + 1;
    localparam int DEN_W  = cfx_pkg::DEN_W;
    localparam int BSQ_W  = cfx_pkg::BSQ_W;

    // saturate a 34-bit signed value, fault in the top bit
    function automatic logic [32:0] sat34(input logic [33:0] v);
        logic [32:0] r;
        if (v[33] == v[32] && v[32] == v[31])
        begin
            r = {1'b0, v[31:0]};
        end
        else if (v[33])
        begin
            r = {1'b1, cfx_pkg::VAL_MIN};
        end
        else
        begin
            r = {1'b1, cfx_pkg::VAL_MAX};
        end
        return r;
    endfunction

    // turn a quotient magnitude into a saturated signed flux, fault in the top bit
    function automatic logic [32:0] flux_out(input logic neg, input logic zero,
                                             input logic dz, input logic ov,
                                             input logic [31:0] q);
        logic [32:0] r;
        if (dz)
        begin
            r = zero ? {1'b1, 32'd0} :
                neg  ? {1'b1, cfx_pkg::VAL_MIN} : {1'b1, cfx_pkg::VAL_MAX};
        end
        else if (neg)
        begin
            r = (ov || q > 32'h8000_0000) ? {1'b1, cfx_pkg::VAL_MIN} : {1'b0, (~q) + 32'd1};
        end
        else
        begin
            r = (ov || q[31]) ? {1'b1, cfx_pkg::VAL_MAX} : {1'b0, q};
        end
        return r;
    endfunction

    // magnitude of a 32-bit signed word
    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? ((~x) + 32'd1) : x;
    endfunction

    // configuration registers
    logic [1:0]  sweep_reg;
    logic [30:0] charge_reg;
    logic        energy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg  <= cfx_pkg::SWEEP_RST;
            charge_reg <= cfx_pkg::CHARGE_RST;
            energy_reg <= cfx_pkg::ENERGY_RST;
        end
        else if (write_enable)
        begin
            unique case (write_index)
                cfx_pkg::REG_SWEEP:  sweep_reg  <= write_data[1:0];
                cfx_pkg::REG_CHARGE: charge_reg <= write_data;
                cfx_pkg::REG_ENERGY: energy_reg <= write_data[0];
                default: ;
            endcase
        end
    end

    // valid line for the whole pipeline
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start};
        end
    end

    assign busy = 1'b0;

    // stage 1: input capture
    cfx_pkg::cell_t   cell1_reg, cell2_reg, cell3_reg, cell4_reg, cell5_reg, cell6_reg;
    logic [30:0]      rho1_reg;

    always_ff @(posedge clk)
    begin
        cell1_reg.f   <= {force_z, force_y, force_x};
        cell1_reg.b   <= {field_z, field_y, field_x};
        cell1_reg.row <= last_in_row;
        rho1_reg      <= density;
    end

    // stage 2: products of the dot and the field square, and the divisor
    logic signed [63:0] pfb2_reg [3];
    logic signed [63:0] pbb2_reg [3];
    logic [DEN_W-1:0]   den2_reg, den3_reg, den4_reg, den5_reg, den6_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pfb2_reg[i] <= $signed(cell1_reg.f[i]) * $signed(cell1_reg.b[i]);
            pbb2_reg[i] <= $signed(cell1_reg.b[i]) * $signed(cell1_reg.b[i]);
        end
        den2_reg  <= charge_reg * rho1_reg;
        cell2_reg <= cell1_reg;
    end

    // stage 3: sums
    logic signed [65:0] dot3_reg;
    logic [BSQ_W-1:0]   bsq3_reg, bsq4_reg, bsq5_reg, bsq6_reg;

    always_ff @(posedge clk)
    begin
        dot3_reg  <= 66'(pfb2_reg[0]) + 66'(pfb2_reg[1]) + 66'(pfb2_reg[2]);
        bsq3_reg  <= $unsigned(pbb2_reg[0]) + $unsigned(pbb2_reg[1])
                     + $unsigned(pbb2_reg[2]);
        den3_reg  <= den2_reg;
        cell3_reg <= cell2_reg;
    end

    // stage 4: magnitudes of the dot and the field
    logic        dneg4_reg;
    logic [63:0] dmag4_reg;
    logic [31:0] bmag4_reg [3];
    logic [65:0] dot_neg;

    assign dot_neg = 66'd0 - $unsigned(dot3_reg);

    always_ff @(posedge clk)
    begin
        dneg4_reg <= dot3_reg[65];
        dmag4_reg <= dot3_reg[65] ? dot_neg[63:0] : dot3_reg[63:0];
        for (int i = 0; i < 3; i++)
        begin
            bmag4_reg[i] <= mag32(cell3_reg.b[i]);
        end
        bsq4_reg  <= bsq3_reg;
        den4_reg  <= den3_reg;
        cell4_reg <= cell3_reg;
    end

    // stage 5: partial products of dot magnitude times field magnitude
    logic [63:0] pl5_reg [3];
    logic [63:0] ph5_reg [3];
    logic [2:0]  qneg5_reg, qneg6_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pl5_reg[i]   <= dmag4_reg[31:0] * bmag4_reg[i];
            ph5_reg[i]   <= dmag4_reg[63:32] * bmag4_reg[i];
            qneg5_reg[i] <= dneg4_reg ^ cell4_reg.b[i][31];
        end
        bsq5_reg  <= bsq4_reg;
        den5_reg  <= den4_reg;
        cell5_reg <= cell4_reg;
    end

    // stage 6: projection numerators
    logic [CNUM_W-1:0] num6_reg [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            num6_reg[i] <= {ph5_reg[i], 32'd0} + {32'd0, pl5_reg[i]};
        end
        qneg6_reg <= qneg5_reg;
        bsq6_reg  <= bsq5_reg;
        den6_reg  <= den5_reg;
        cell6_reg <= cell5_reg;
    end

    // projection dividers
    logic [Q_W-1:0] pq   [3];
    logic           povf [3];

    for (genvar i = 0; i < 3; i++) begin : g_pdiv
        cfx_div #(
            .NUM_W (CNUM_W),
            .DEN_W (BSQ_W),
            .Q_W   (Q_W)
        ) u_div (
            .clk (clk),
            .num (num6_reg[i]),
            .den (bsq6_reg),
            .quo (pq[i]),
            .ovf (povf[i])
        );
    end

    cfx_pkg::side1_t side1_in, side1_out;

    assign side1_in.f        = cell6_reg.f;
    assign side1_in.b        = cell6_reg.b;
    assign side1_in.qneg     = qneg6_reg;
    assign side1_in.bsq_zero = (bsq6_reg == '0);
    assign side1_in.den_zero = (den6_reg == '0);
    assign side1_in.den      = den6_reg;
    assign side1_in.row      = cell6_reg.row;

    cfx_delay #(
        .W     ($bits(cfx_pkg::side1_t)),
        .DEPTH (DL)
    ) u_side1 (
        .clk (clk),
        .d   (side1_in),
        .q   (side1_out)
    );

    // stage c1: clean force with saturation
    logic [32:0] cf_sat [3];
    logic [31:0] cf1_reg [3];
    logic        fault1_reg;
    logic [2:0][31:0] b1_reg;
    logic [DEN_W-1:0] denc1_reg, denc2_reg, denc3_reg;
    logic        dz1_reg, row1_reg;

    for (genvar i = 0; i < 3; i++) begin : g_clean
        logic [33:0] f34;
        logic [33:0] q34;
        assign f34 = {{2{side1_out.f[i][31]}}, side1_out.f[i]};
        assign q34 = side1_out.qneg[i] ? (34'd0 - {2'b0, pq[i]}) : {2'b0, pq[i]};
        assign cf_sat[i] = side1_out.bsq_zero ? {1'b0, side1_out.f[i]}
                                              : sat34(f34 - q34);
    end

    // the projection quotient only counts when the field is nonzero
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            cf1_reg[i] <= cf_sat[i][31:0];
        end
        fault1_reg <= cf_sat[0][32] | cf_sat[1][32] | cf_sat[2][32]
                      | ((povf[0] | povf[1] | povf[2]) & ~side1_out.bsq_zero)
                      | side1_out.den_zero;
        b1_reg     <= side1_out.b;
        denc1_reg  <= side1_out.den;
        dz1_reg    <= side1_out.den_zero;
        row1_reg   <= side1_out.row;
    end

    // stage c2: pick the two transverse axes and form energy products
    logic [31:0] fp_sel, fq_sel, bp_sel, bq_sel;

    always_comb
    begin
        unique case (sweep_reg)
            cfx_pkg::SWEEP_X:
            begin
                fp_sel = cf1_reg[1]; fq_sel = cf1_reg[2];
                bp_sel = b1_reg[1];  bq_sel = b1_reg[2];
            end
            cfx_pkg::SWEEP_Y:
            begin
                fp_sel = cf1_reg[2]; fq_sel = cf1_reg[0];
                bp_sel = b1_reg[2];  bq_sel = b1_reg[0];
            end
            cfx_pkg::SWEEP_Z:
            begin
                fp_sel = cf1_reg[0]; fq_sel = cf1_reg[1];
                bp_sel = b1_reg[0];  bq_sel = b1_reg[1];
            end
            default:
            begin
                fp_sel = cf1_reg[1]; fq_sel = cf1_reg[2];
                bp_sel = b1_reg[1];  bq_sel = b1_reg[2];
            end
        endcase
    end

    logic signed [63:0] e1c2_reg, e2c2_reg;
    logic [31:0] mp2_reg, mq2_reg, mp3_reg, mq3_reg;
    logic        np2_reg, nq2_reg, np3_reg, nq3_reg;
    logic [31:0] cf2_reg [3];
    logic [31:0] cf3_reg [3];
    logic        fault2_reg, fault3_reg, dz2_reg, dz3_reg, row2_reg, row3_reg;

    always_ff @(posedge clk)
    begin
        e1c2_reg   <= $signed(fq_sel) * $signed(bp_sel);
        e2c2_reg   <= $signed(fp_sel) * $signed(bq_sel);
        mp2_reg    <= mag32(fq_sel);
        np2_reg    <= fq_sel[31];
        mq2_reg    <= mag32(fp_sel);
        nq2_reg    <= !fp_sel[31] && (fp_sel != '0);
        cf2_reg    <= cf1_reg;
        fault2_reg <= fault1_reg;
        denc2_reg  <= denc1_reg;
        dz2_reg    <= dz1_reg;
        row2_reg   <= row1_reg;
    end

    // stage c3: energy numerator difference
    logic signed [65:0] ed3_reg;

    always_ff @(posedge clk)
    begin
        ed3_reg    <= 66'(e1c2_reg) - 66'(e2c2_reg);
        mp3_reg    <= mp2_reg;
        np3_reg    <= np2_reg;
        mq3_reg    <= mq2_reg;
        nq3_reg    <= nq2_reg;
        cf3_reg    <= cf2_reg;
        fault3_reg <= fault2_reg;
        denc3_reg  <= denc2_reg;
        dz3_reg    <= dz2_reg;
        row3_reg   <= row2_reg;
    end

    // stage c4: flux numerators, scaled by the fraction bits
    logic [65:0]       ed_neg;
    logic [63:0]       emag;
    logic [FNUM_W-1:0] fnum4_reg [3];
    logic [DEN_W-1:0]  denc4_reg;
    cfx_pkg::side2_t   side2_in, side2_out;

    assign ed_neg = 66'd0 - $unsigned(ed3_reg);
    assign emag   = ed3_reg[65] ? ed_neg[63:0] : ed3_reg[63:0];

    always_ff @(posedge clk)
    begin
        fnum4_reg[0]      <= FNUM_W'(mp3_reg) << (2 * FRAC_BITS);
        fnum4_reg[1]      <= FNUM_W'(mq3_reg) << (2 * FRAC_BITS);
        fnum4_reg[2]      <= FNUM_W'(emag) << FRAC_BITS;
        denc4_reg         <= denc3_reg;
        side2_in.cf       <= {cf3_reg[2], cf3_reg[1], cf3_reg[0]};
        side2_in.fault    <= fault3_reg;
        side2_in.den_zero <= dz3_reg;
        side2_in.row      <= row3_reg;
        side2_in.neg      <= {ed3_reg[65], nq3_reg, np3_reg};
        side2_in.zero     <= {emag == '0, mq3_reg == '0, mp3_reg == '0};
    end

    // flux dividers: transverse p, transverse q, energy
    logic [Q_W-1:0] fq   [3];
    logic           fovf [3];

    for (genvar i = 0; i < 3; i++) begin : g_fdiv
        cfx_div #(
            .NUM_W (FNUM_W),
            .DEN_W (DEN_W),
            .Q_W   (Q_W)
        ) u_div (
            .clk (clk),
            .num (fnum4_reg[i]),
            .den (denc4_reg),
            .quo (fq[i]),
            .ovf (fovf[i])
        );
    end

    cfx_delay #(
        .W     ($bits(cfx_pkg::side2_t)),
        .DEPTH (DL)
    ) u_side2 (
        .clk (clk),
        .d   (side2_in),
        .q   (side2_out)
    );

    // output stage: saturate fluxes and place them by sweep axis
    logic [32:0] res [3];
    logic [31:0] flx_next, fly_next, flz_next, en_next;
    logic        fault_next;
    logic        en_fault;

    for (genvar i = 0; i < 3; i++) begin : g_res
        assign res[i] = flux_out(side2_out.neg[i], side2_out.zero[i],
                                 side2_out.den_zero, fovf[i], fq[i]);
    end

    assign en_fault = energy_reg & res[2][32];

    always_comb
    begin
        flx_next   = '0;
        fly_next   = '0;
        flz_next   = '0;
        en_next    = energy_reg ? res[2][31:0] : '0;
        fault_next = side2_out.fault | res[0][32] | res[1][32] | en_fault;
        unique case (sweep_reg)
            cfx_pkg::SWEEP_X:
            begin
                fly_next = res[0][31:0];
                flz_next = res[1][31:0];
            end
            cfx_pkg::SWEEP_Y:
            begin
                flz_next = res[0][31:0];
                flx_next = res[1][31:0];
            end
            cfx_pkg::SWEEP_Z:
            begin
                flx_next = res[0][31:0];
                fly_next = res[1][31:0];
            end
            default:
            begin
                en_next    = '0;
                fault_next = side2_out.fault;
            end
        endcase
    end

    logic [31:0] cfx_reg, cfy_reg, cfz_reg, flx_reg, fly_reg, flz_reg, en_reg;
    logic        fault_reg, row_reg;

    always_ff @(posedge clk)
    begin
        cfx_reg   <= side2_out.cf[0];
        cfy_reg   <= side2_out.cf[1];
        cfz_reg   <= side2_out.cf[2];
        flx_reg   <= flx_next;
        fly_reg   <= fly_next;
        flz_reg   <= flz_next;
        en_reg    <= en_next;
        fault_reg <= fault_next;
        row_reg   <= side2_out.row;
    end

    assign done          = vld_reg[LAT-1];
    assign clean_force_x = $signed(cfx_reg);
    assign clean_force_y = $signed(cfy_reg);
    assign clean_force_z = $signed(cfz_reg);
    assign flux_field_x  = $signed(flx_reg);
    assign flux_field_y  = $signed(fly_reg);
    assign flux_field_z  = $signed(flz_reg);
    assign flux_energy   = $signed(en_reg);
    assign divide_fault  = fault_reg;
    assign row_end       = row_reg;

endmodule

FILE: src/cfx_delay.sv
// register line of DEPTH registers that delays a word
module cfx_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] line_reg [DEPTH];

    // shift line
    always_ff @(posedge clk)
    begin
        line_reg[0] <= d;
        for (int i = 1; i < DEPTH; i++)
        begin
            line_reg[i] <= line_reg[i-1];
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

FILE: src/cfx_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow check
module cfx_div #(
    parameter int NUM_W = 96,
    parameter int DEN_W = 64,
    parameter int Q_W   = 32
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo,
    output logic             ovf
);

    localparam int HI_W  = NUM_W - Q_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [CMP_W-1:0] hi_ext;
    logic [CMP_W-1:0] den_ext;

    logic [DEN_W-1:0] rem_reg [Q_W];
    logic [Q_W-1:0]   lo_reg  [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic             ovf_reg [Q_W+1];
    logic [Q_W-1:0]   quo_reg [1:Q_W];

    assign hi_ext  = CMP_W'(num[NUM_W-1:Q_W]);
    assign den_ext = CMP_W'(den);

    // entry: upper part is the first partial remainder, quotient too big if it reaches den
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= hi_ext[DEN_W-1:0];
        lo_reg[0]  <= num[Q_W-1:0];
        den_reg[0] <= den;
        ovf_reg[0] <= (hi_ext >= den_ext);
    end

    // one trial subtract per stage
    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        logic [DEN_W:0] trial;
        logic [DEN_W:0] den_w;
        logic [DEN_W:0] diff;
        logic           ge;
        logic [Q_W-1:0] quo_prev;

        assign trial = {rem_reg[s], lo_reg[s][Q_W-1]};
        assign den_w = {1'b0, den_reg[s]};
        assign diff  = trial - den_w;
        assign ge    = (trial >= den_w);

        if (s == 0) begin : g_first
            assign quo_prev = '0;
        end else begin : g_next
            assign quo_prev = quo_reg[s];
        end

        always_ff @(posedge clk)
        begin
            quo_reg[s+1] <= {quo_prev[Q_W-2:0], ge};
            ovf_reg[s+1] <= ovf_reg[s];
        end

        if (s + 1 < Q_W) begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[s+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                lo_reg[s+1]  <= {lo_reg[s][Q_W-2:0], 1'b0};
                den_reg[s+1] <= den_reg[s];
            end
        end
    end

    assign quo = quo_reg[Q_W];
    assign ovf = ovf_reg[Q_W];

endmodule

FILE: tb/sv/tb_top.sv
// testbench for the cosmic-ray flux cell: random and directed cells checked against a predictor
`timescale 1ns / 100ps

module tb_top;

    // one input cell
    typedef struct {
        logic signed [31:0] frc [3];
        logic signed [31:0] fld [3];
        logic [30:0]        rho;
        logic               last;
    } cell_word_t;

    // one expected output word
    typedef struct {
        logic [31:0] cf [3];
        logic [31:0] fl [3];
        logic [31:0] en;
        logic        fault;
        logic        row;
    } flux_word_t;

    typedef logic signed [159:0] wide_t;

    localparam int FRAC = 16;
    localparam int LATENCY = 77;
    localparam int CYCLE_LIMIT = 300000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic write_enable;
    logic [1:0] write_index;
    logic [30:0] write_data;
    logic signed [31:0] force_x, force_y, force_z;
    logic signed [31:0] field_x, field_y, field_z;
    logic [30:0] density;
    logic last_in_row;
    logic done;
    logic signed [31:0] clean_force_x, clean_force_y, clean_force_z;
    logic signed [31:0] flux_field_x, flux_field_y, flux_field_z;
    logic signed [31:0] flux_energy;
    logic divide_fault;
    logic row_end;

    cell_word_t pending_cells[$];
    flux_word_t expected_flux[$];

    // shadow of the configuration registers
    logic [1:0]  sh_sweep;
    logic [30:0] sh_charge;
    logic        sh_energy;

    logic        took_cell;
    logic        steady;
    int          mismatches;
    int          cycles;

    cosmic_ray_flux_cell dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .write_enable(write_enable), .write_index(write_index), .write_data(write_data),
        .force_x(force_x), .force_y(force_y), .force_z(force_z),
        .field_x(field_x), .field_y(field_y), .field_z(field_z),
        .density(density), .last_in_row(last_in_row), .done(done),
        .clean_force_x(clean_force_x), .clean_force_y(clean_force_y),
        .clean_force_z(clean_force_z), .flux_field_x(flux_field_x),
        .flux_field_y(flux_field_y), .flux_field_z(flux_field_z),
        .flux_energy(flux_energy), .divide_fault(divide_fault), .row_end(row_end)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // clamp to 32 bits, returns {clamped, value}
    function automatic logic [32:0] clamp32(input wide_t v);
        if (v > wide_t'(32'sh7fff_ffff))
            return {1'b1, cfx_pkg::VAL_MAX};
        if (v < -wide_t'(64'sh8000_0000))
            return {1'b1, cfx_pkg::VAL_MIN};
        return {1'b0, v[31:0]};
    endfunction

    // flux quotient with zero-divisor handling, returns {fault, value}
    function automatic logic [32:0] flux_quot(input wide_t num, input int sh, input wide_t den);
        if (den == 0)
        begin
            if (num < 0)
                return {1'b1, cfx_pkg::VAL_MIN};
            if (num == 0)
                return 33'd0;
            return {1'b1, cfx_pkg::VAL_MAX};
        end
        return clamp32((num <<< sh) / den);
    endfunction

    // expected output of one cell under the current configuration
    function automatic flux_word_t cell_flux(input cell_word_t c);
        flux_word_t r;
        wide_t f [3];
        wide_t b [3];
        wide_t fc [3];
        wide_t bsq, dot, q, den, rhow, num;
        logic [32:0] s;
        logic flt;
        int p, k;
        flt = 1'b0;
        bsq = 0;
        dot = 0;
        for (int i = 0; i < 3; i++)
        begin
            f[i] = c.frc[i];
            b[i] = c.fld[i];
            bsq = bsq + b[i] * b[i];
            dot = dot + f[i] * b[i];
        end
        // remove the part parallel to the field
        for (int i = 0; i < 3; i++)
        begin
            if (bsq == 0)
                r.cf[i] = c.frc[i];
            else
            begin
                q = (dot * b[i]) / bsq;
                s = clamp32(f[i] - q);
                flt |= s[32];
                r.cf[i] = s[31:0];
            end
            fc[i] = $signed(r.cf[i]);
            r.fl[i] = '0;
        end
        den = sh_charge;
        rhow = c.rho;
        den = den * rhow;
        if (den == 0)
            flt = 1'b1;
        r.en = '0;
        if (sh_sweep != 2'd3)
        begin
            p = (sh_sweep + 1) % 3;
            k = (sh_sweep + 2) % 3;
            s = flux_quot(fc[k], 2 * FRAC, den);
            flt |= s[32];
            r.fl[p] = s[31:0];
            s = flux_quot(-fc[p], 2 * FRAC, den);
            flt |= s[32];
            r.fl[k] = s[31:0];
            if (sh_energy)
            begin
                num = fc[k] * b[p] - fc[p] * b[k];
                s = flux_quot(num, FRAC, den);
                flt |= s[32];
                r.en = s[31:0];
            end
        end
        r.fault = flt;
        r.row = c.last;
        return r;
    endfunction

    // driver: present queued cells, idle at random
    always @(negedge clk)
    begin
        if (rst_n && (!start || took_cell))
        begin
            if (pending_cells.size() > 0 && (steady || $urandom_range(99) >= 19))
            begin
                cell_word_t c;
                c = pending_cells.pop_front();
                force_x <= c.frc[0];
                force_y <= c.frc[1];
                force_z <= c.frc[2];
                field_x <= c.fld[0];
                field_y <= c.fld[1];
                field_z <= c.fld[2];
                density <= c.rho;
                last_in_row <= c.last;
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: accept cells, track configuration, check results
    always @(posedge clk)
    begin
        cell_word_t c;
        flux_word_t e;
        took_cell <= rst_n && start && !busy;
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            if (write_enable)
            begin
                if (write_index == cfx_pkg::REG_SWEEP)
                    sh_sweep <= write_data[1:0];
                else if (write_index == cfx_pkg::REG_CHARGE)
                    sh_charge <= write_data;
                else if (write_index == cfx_pkg::REG_ENERGY)
                    sh_energy <= write_data[0];
            end
            if (start && !busy)
            begin
                c.frc[0] = force_x;
                c.frc[1] = force_y;
                c.frc[2] = force_z;
                c.fld[0] = field_x;
                c.fld[1] = field_y;
                c.fld[2] = field_z;
                c.rho = density;
                c.last = last_in_row;
                expected_flux.push_back(cell_flux(c));
            end
            if (done)
            begin
                if (expected_flux.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected word at cycle %0d", cycles);
                end
                else
                begin
                    e = expected_flux.pop_front();
                    if (e.cf[0] !== clean_force_x || e.cf[1] !== clean_force_y
                        || e.cf[2] !== clean_force_z || e.fl[0] !== flux_field_x
                        || e.fl[1] !== flux_field_y || e.fl[2] !== flux_field_z
                        || e.en !== flux_energy || e.fault !== divide_fault
                        || e.row !== row_end)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                        begin
                            $write("mismatch cycle %0d exp cf %h %h %h fl %h %h %h en %h f%b r%b",
                                cycles, e.cf[0], e.cf[1], e.cf[2], e.fl[0], e.fl[1], e.fl[2],
                                e.en, e.fault, e.row);
                            $display(" got cf %h %h %h fl %h %h %h en %h f%b r%b",
                                clean_force_x, clean_force_y, clean_force_z, flux_field_x,
                                flux_field_y, flux_field_z, flux_energy, divide_fault,
                                row_end);
                        end
                    end
                end
            end
        end
    end

    // queue one cell
    task automatic add_cell(input logic [31:0] fx, fy, fz, bx, by, bz,
                            input logic [30:0] rho, input logic last);
        cell_word_t c;
        c.frc[0] = fx;
        c.frc[1] = fy;
        c.frc[2] = fz;
        c.fld[0] = bx;
        c.fld[1] = by;
        c.fld[2] = bz;
        c.rho = rho;
        c.last = last;
        pending_cells.push_back(c);
    endtask

    // random component: full range, modest, or zero
    function automatic logic [31:0] rand_comp();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4)
            return $urandom();
        if (sel < 9)
            return 32'($signed($urandom_range(2 * 1048576)) - 1048576);
        return '0;
    endfunction

    function automatic logic [30:0] rand_rho();
        int sel;
        sel = $urandom_range(19);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return 31'h7fff_ffff;
        if (sel < 8)
            return 31'($urandom());
        return 31'($urandom_range(262144, 1));
    endfunction

    // wait until every word is back and the pipeline is empty
    task automatic drain();
        while (pending_cells.size() > 0 || start || expected_flux.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // write all three registers while idle
    task automatic set_config(input logic [1:0] sweep, input logic [30:0] charge,
                              input logic energy);
        @(negedge clk);
        write_enable <= 1'b1;
        write_index <= cfx_pkg::REG_SWEEP;
        write_data <= 31'(sweep);
        @(negedge clk);
        write_index <= cfx_pkg::REG_CHARGE;
        write_data <= charge;
        @(negedge clk);
        write_index <= cfx_pkg::REG_ENERGY;
        write_data <= 31'(energy);
        @(negedge clk);
        write_enable <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        logic [1:0]  sweeps [6];
        logic [30:0] charges [6];
        logic        energies [6];
        rst_n = 1'b0;
        start = 1'b0;
        write_enable = 1'b0;
        write_index = cfx_pkg::REG_SWEEP;
        write_data = '0;
        force_x = '0;
        force_y = '0;
        force_z = '0;
        field_x = '0;
        field_y = '0;
        field_z = '0;
        density = '0;
        last_in_row = 1'b0;
        sh_sweep = cfx_pkg::SWEEP_RST;
        sh_charge = cfx_pkg::CHARGE_RST;
        sh_energy = cfx_pkg::ENERGY_RST;
        steady = 1'b0;
        mismatches = 0;
        cycles = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed cells under the reset configuration
        add_cell(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0, 31'h1_0000, 0);
        add_cell(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 31'h1_0000, 1);
        add_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 31'd1, 0);
        add_cell(32'h0001_0000, 32'h0001_0000, 0, 32'h0001_0000, 0, 0, 31'h1_0000, 0);
        add_cell(32'h0002_0000, 0, 0, 32'h0001_0000, 0, 0, 31'h2_0000, 1);
        add_cell(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h7fff_ffff,
                 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff, 0);
        add_cell(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001,
                 32'hffff_ffff, 32'h8000_0000, 31'h1_0000, 0);
        add_cell(32'h0005_0000, 32'hfffb_0000, 32'h0001_0000, 0, 32'h0003_0000, 0, 0, 1);
        add_cell(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0);
        add_cell(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 32'h0001_0000, 31'd1, 0);
        add_cell(32'h0000_0001, 32'hffff_ffff, 32'h0000_0100, 32'h0000_0003,
                 32'h0000_0005, 32'hffff_fff9, 31'h0000_4000, 1);
        add_cell(32'h1234_5678, 32'hedcb_a987, 32'h0fff_0000, 32'h0100_0000,
                 32'hff00_0000, 32'h0080_0000, 31'h7fff_ffff, 0);
        drain();

        // configuration phases, extremes and unused sweep code among them
        sweeps = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1};
        charges = '{31'd1, 31'h7fff_ffff, 31'h1_0000, 31'd0, 31'h1_8000, 31'h0000_4000};
        energies = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
        for (int ph = 0; ph < 6; ph++)
        begin
            set_config(sweeps[ph], charges[ph], energies[ph]);
            steady = (ph == 4);
            for (int n = 0; n < 82; n++)
            begin
                logic [31:0] bx, by, bz;
                bx = rand_comp();
                by = rand_comp();
                bz = rand_comp();
                if ($urandom_range(9) == 0)
                begin
                    bx = '0;
                    by = '0;
                    bz = '0;
                end
                add_cell(rand_comp(), rand_comp(), rand_comp(), bx, by, bz, rand_rho(),
                         1'($urandom_range(1)));
            end
            drain();
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
